// ===== rtl/wjd_pkg.sv =====
// ----------------------------------------------------------------------------
// wjd_pkg: shared types and constants for the weighted Jaccard distance block
// Field widths, fixed-point formats and request payload structs.
// ----------------------------------------------------------------------------
package wjd_pkg;

  localparam int COUNT_WIDTH      = 17;
  localparam int USER_INDEX_WIDTH = 16;

  localparam int INDEX_WIDTH = 16;   // fixed port width of user indexes
  localparam int COEF_WIDTH  = 24;   // unsigned Q8.16
  localparam int FRAC_BITS   = 16;
  localparam int RATIO_WIDTH = 2 * FRAC_BITS;   // unsigned Q16.16
  localparam int SUM_WIDTH   = 56;   // unsigned Q40.16
  localparam int DIST_WIDTH  = 32;   // signed Q16.16

  localparam int IDX_KEEP = (USER_INDEX_WIDTH < INDEX_WIDTH) ? USER_INDEX_WIDTH : INDEX_WIDTH;
  localparam logic [INDEX_WIDTH-1:0] IDX_MASK =
    INDEX_WIDTH'((33'd1 << IDX_KEEP) - 33'd1);

  localparam logic [SUM_WIDTH-1:0] ONE_Q16 = SUM_WIDTH'(64'h0000_0000_0001_0000);
  // largest quotient whose distance still fits: 2^31 + 1.0
  localparam logic [SUM_WIDTH-1:0] Q_LIMIT = SUM_WIDTH'(64'h0000_0000_8001_0000);
  localparam logic [DIST_WIDTH-1:0] DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

  localparam int STEP_CNT_W = $clog2(SUM_WIDTH);

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] user_a_index;
    logic [INDEX_WIDTH-1:0] user_b_index;
    logic                   a_present;
    logic                   b_present;
    logic [COEF_WIDTH-1:0]  coef_a;
    logic [COEF_WIDTH-1:0]  coef_b;
    logic [COEF_WIDTH-1:0]  popularity;
    logic                   last_article;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0]       pair_a;
    logic [INDEX_WIDTH-1:0]       pair_b;
    logic signed [DIST_WIDTH-1:0] distance;
    logic                         union_empty;
    logic                         value_clipped;
  } out_item_t;

endpackage

// ===== rtl/weighted_jaccard_distance.sv =====
// ----------------------------------------------------------------------------
// weighted_jaccard_distance: weighted Jaccard distance of one user pair
// Accumulates ratio-weighted popularity and union count over articles and
// emits 1 - sum / union as signed Q16.16 on the last article of a pair.
// ----------------------------------------------------------------------------
// Usage: feed the articles of one user pair as input requests, the last one
// flagged with last_article; exactly one result request follows the last
// article. The block handles one article at a time. An article where both
// users are present is accepted, runs the bit-serial coefficient divider
// (one quotient bit per cycle, each bit folded straight into a shift-add
// multiply by the popularity) and is accumulated. An article where at most
// one user is present is accepted and then accumulated. The last article
// adds the bit-serial sum / union division (one bit per cycle over the
// 56-bit sum, skipped when the union is empty) and then loads the output
// register once it is free. Results wait in that output register, so new
// articles of the next pair are accepted while a result is still pending.
// Zero or very small coefficients saturate the ratio to 2^32-1 and set
// value_clipped, as do sum, count and distance saturation.
// ----------------------------------------------------------------------------
module weighted_jaccard_distance (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wjd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wjd_pkg::out_item_t out_data
);

  localparam int CW = wjd_pkg::COUNT_WIDTH;
  localparam int KW = wjd_pkg::COEF_WIDTH;
  localparam int RW = wjd_pkg::RATIO_WIDTH;
  localparam int SW = wjd_pkg::SUM_WIDTH;
  localparam int FB = wjd_pkg::FRAC_BITS;
  localparam int NW = wjd_pkg::STEP_CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,    // ratio divider + serial multiply
    ST_ACC,    // accumulate term and union count
    ST_FDIV,   // sum / union divider
    ST_EMIT    // load result into output register
  } state_t;

  state_t state_r;

  // accumulated pair state
  logic [SW-1:0] sum_r;
  logic [CW-1:0] union_r;
  logic          clip_r;

  // current article
  logic [wjd_pkg::INDEX_WIDTH-1:0] pair_a_r, pair_b_r;
  logic          both_r, any_r, last_r, force_r;
  logic [KW-1:0] lo_r, pop_r, rem_r;
  logic [RW-1:0] dvd_r;
  logic [SW-1:0] prod_r;
  logic [NW-1:0] cnt_r;

  // final divider
  logic [SW-1:0] fq_r;
  logic [CW-1:0] frem_r;

  // output register
  logic               out_valid_r;
  wjd_pkg::out_item_t out_data_r;

  // ---- combinational datapath ----
  logic [KW-1:0] hi_c, lo_c;
  logic          sat_c;
  logic [KW:0]   trial, diff;
  logic          ge, qbit;
  logic [KW-1:0] rem_nxt;
  logic [SW-1:0] prod_nxt;
  logic [SW:0]   sum_add;
  logic [SW-1:0] sum_nxt;
  logic [CW-1:0] union_nxt;
  logic          clip_nxt;
  logic [CW:0]   ftrial, fdiff;
  logic          fge;
  logic [CW-1:0] frem_nxt;
  logic          union_zero, q_over;
  logic [wjd_pkg::DIST_WIDTH-1:0] dist_c;
  logic          slot_free;

  always_comb begin
    // ratio setup: max/min, saturate when max >= min * 2^16 (covers min == 0)
    hi_c  = (in_data.coef_a > in_data.coef_b) ? in_data.coef_a : in_data.coef_b;
    lo_c  = (in_data.coef_a > in_data.coef_b) ? in_data.coef_b : in_data.coef_a;
    sat_c = lo_c <= KW'(hi_c >> FB);

    // restoring divide step, one quotient bit
    trial   = {rem_r, dvd_r[RW-1]};
    diff    = trial - {1'b0, lo_r};
    ge      = trial >= {1'b0, lo_r};
    qbit    = force_r | ge;
    rem_nxt = ge ? diff[KW-1:0] : trial[KW-1:0];
    // quotient arrives MSB first: product = product * 2 + qbit * popularity
    prod_nxt = {prod_r[SW-2:0], 1'b0} + (qbit ? SW'(pop_r) : '0);

    // accumulate with saturation
    sum_add   = {1'b0, sum_r} + (SW+1)'(prod_r >> FB);
    sum_nxt   = sum_r;
    union_nxt = union_r;
    clip_nxt  = clip_r;
    if (both_r) begin
      if (sum_add[SW]) begin
        sum_nxt  = '1;
        clip_nxt = 1'b1;
      end else begin
        sum_nxt = sum_add[SW-1:0];
      end
    end
    if (any_r) begin
      if (&union_r) begin
        clip_nxt = 1'b1;
      end else begin
        union_nxt = union_r + CW'(1);
      end
    end

    // final divide step, quotient shifts into fq_r
    ftrial   = {frem_r, fq_r[SW-1]};
    fdiff    = ftrial - {1'b0, union_r};
    fge      = ftrial >= {1'b0, union_r};
    frem_nxt = fge ? fdiff[CW-1:0] : ftrial[CW-1:0];

    // distance
    union_zero = (union_r == '0);
    q_over     = fq_r > wjd_pkg::Q_LIMIT;
    if (union_zero) begin
      dist_c = '0;
    end else if (q_over) begin
      dist_c = wjd_pkg::DIST_MIN;
    end else begin
      dist_c = wjd_pkg::DIST_WIDTH'(wjd_pkg::ONE_Q16 - fq_r);
    end

    slot_free = !out_valid_r || out_ready;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      union_r     <= '0;
      clip_r      <= 1'b0;
    end else begin
      // the emit step reloads the output register itself
      if (out_valid_r && out_ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            pair_a_r <= in_data.user_a_index & wjd_pkg::IDX_MASK;
            pair_b_r <= in_data.user_b_index & wjd_pkg::IDX_MASK;
            both_r   <= in_data.a_present & in_data.b_present;
            any_r    <= in_data.a_present | in_data.b_present;
            last_r   <= in_data.last_article;
            force_r  <= sat_c;
            lo_r     <= lo_c;
            pop_r    <= in_data.popularity;
            rem_r    <= KW'(hi_c >> FB);
            dvd_r    <= {hi_c[FB-1:0], {FB{1'b0}}};
            prod_r   <= '0;
            cnt_r    <= NW'(RW - 1);
            if (in_data.a_present && in_data.b_present) begin
              if (sat_c) begin
                clip_r <= 1'b1;
              end
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_ACC;
            end
          end
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          dvd_r  <= {dvd_r[RW-2:0], 1'b0};
          prod_r <= prod_nxt;
          cnt_r  <= cnt_r - NW'(1);
          if (cnt_r == '0) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_r   <= sum_nxt;
          union_r <= union_nxt;
          clip_r  <= clip_nxt;
          fq_r    <= sum_nxt;
          frem_r  <= '0;
          cnt_r   <= NW'(SW - 1);
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (union_nxt == '0) begin
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          frem_r <= frem_nxt;
          fq_r   <= {fq_r[SW-2:0], fge};
          cnt_r  <= cnt_r - NW'(1);
          if (cnt_r == '0) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r                <= 1'b1;
            out_data_r.pair_a          <= pair_a_r;
            out_data_r.pair_b          <= pair_b_r;
            out_data_r.distance        <= dist_c;
            out_data_r.union_empty     <= union_zero;
            out_data_r.value_clipped   <= clip_r | (!union_zero & q_over);
            sum_r   <= '0;
            union_r <= '0;
            clip_r  <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a result only appears out of the emit step
  a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("result appeared outside emit step");

  // never divide the sum by an empty union
  a_fdiv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FDIV) |-> (union_r != '0))
    else $error("final division with zero union");

  // empty union reports zero distance
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.union_empty) |-> (out_data.distance == '0))
    else $error("empty union with nonzero distance");

  // accumulated state is cleared once a result is loaded
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free) |=> (union_r == '0 && sum_r == '0 && !clip_r))
    else $error("pair state not cleared after result");
`endif

endmodule

// ===== verif/weighted_jaccard_distance_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_jaccard_distance_tb: self-checking bench for the pair distance unit
// A directed table of corner articles, then random user pairs under random
// valid/ready idling and a long output hold-off. Every result request is
// compared field by field to a hand-derived result or the accumulator model.
// ----------------------------------------------------------------------------
module weighted_jaccard_distance_tb;

  localparam int COEF_W = wjd_pkg::COEF_WIDTH;
  localparam int IDX_W  = wjd_pkg::INDEX_WIDTH;
  localparam int DIST_W = wjd_pkg::DIST_WIDTH;
  localparam int FRAC   = wjd_pkg::FRAC_BITS;

  // Model limits, kept 64 bits wide so no intermediate value wraps.
  localparam logic [63:0] RATIO_SAT = 64'hFFFF_FFFF;
  localparam logic [63:0] SUM_SAT   = (64'd1 << wjd_pkg::SUM_WIDTH) - 64'd1;
  localparam logic [63:0] COUNT_SAT = (64'd1 << wjd_pkg::COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] UNIT_Q16  = 64'd1 << FRAC;
  // any quotient above this pushes the distance below -2^31
  localparam logic [63:0] DIST_LOW_QUOT = (64'd1 << (DIST_W - 1)) + UNIT_Q16;
  localparam logic [DIST_W-1:0] D_MIN = wjd_pkg::DIST_MIN;

  localparam logic [COEF_W-1:0] C_ONE = 24'h01_0000;   // 1.0 in Q8.16
  localparam logic [COEF_W-1:0] C_MAX = 24'hFF_FFFF;

  localparam int unsigned HOLD_OFF_CYCLES = 400;

  typedef struct {
    wjd_pkg::in_item_t  req;
    bit                 typed;   // want holds a hand-derived result
    wjd_pkg::out_item_t want;
  } directed_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  wjd_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  wjd_pkg::out_item_t out_data;

  // accumulator model state
  logic [63:0] acc_sum   = '0;
  logic [63:0] acc_union = '0;
  bit          acc_clip  = 1'b0;

  wjd_pkg::out_item_t expected_distances[$];
  directed_row_t      plan[$];
  int unsigned        mismatches = 0;

  // traffic shaping, set by the stimulus, read by the sender and the sink
  bit sender_idles = 1'b1;
  bit sink_idles   = 1'b1;
  bit hold_off_req = 1'b0;

  weighted_jaccard_distance i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Coefficients and popularity share one spread: zero, tiny, full scale,
  // around 1.0 and anything at all.
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COEF_W'($urandom_range(1, 3));
      2:       return C_MAX;
      3, 4:    return COEF_W'($urandom_range(32'h0000_8000, 32'h0002_0000));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic wjd_pkg::in_item_t article(
    input logic [IDX_W-1:0] ua, ub,
    input bit ap, bp,
    input logic [COEF_W-1:0] ca, cb, pop,
    input bit last
  );
    wjd_pkg::in_item_t a;
    a.user_a_index = ua;
    a.user_b_index = ub;
    a.a_present    = ap;
    a.b_present    = bp;
    a.coef_a       = ca;
    a.coef_b       = cb;
    a.popularity   = pop;
    a.last_article = last;
    return a;
  endfunction

  function automatic wjd_pkg::out_item_t pair_result(
    input logic [IDX_W-1:0] pa, pb,
    input logic [DIST_W-1:0] dist_val,
    input bit empty, clipped
  );
    wjd_pkg::out_item_t r;
    r.pair_a        = pa;
    r.pair_b        = pb;
    r.distance      = dist_val;
    r.union_empty   = empty;
    r.value_clipped = clipped;
    return r;
  endfunction

  // Accumulator model: folds one accepted article into the running pair
  // state and, on the last article, produces the distance result.
  function automatic void fold_article(input wjd_pkg::in_item_t a, output bit emits,
                                       output wjd_pkg::out_item_t d);
    logic [63:0] big, tiny, ratio, term, quot;
    emits = 1'b0;
    d     = '0;
    if (a.a_present && a.b_present) begin
      big  = 64'((a.coef_a > a.coef_b) ? a.coef_a : a.coef_b);
      tiny = 64'((a.coef_a > a.coef_b) ? a.coef_b : a.coef_a);
      if (tiny == 0) begin
        // zero coefficient: ratio pinned at full scale
        ratio    = RATIO_SAT;
        acc_clip = 1'b1;
      end else begin
        ratio = (big << FRAC) / tiny;
        if (ratio > RATIO_SAT) begin
          ratio    = RATIO_SAT;
          acc_clip = 1'b1;
        end
      end
      term = (ratio * 64'(a.popularity)) >> FRAC;
      if (acc_sum > SUM_SAT - term) begin
        acc_sum  = SUM_SAT;
        acc_clip = 1'b1;
      end else begin
        acc_sum = acc_sum + term;
      end
    end
    if (a.a_present || a.b_present) begin
      if (acc_union >= COUNT_SAT) begin
        acc_union = COUNT_SAT;
        acc_clip  = 1'b1;
      end else begin
        acc_union = acc_union + 64'd1;
      end
    end
    if (a.last_article) begin
      emits           = 1'b1;
      d.pair_a        = a.user_a_index & wjd_pkg::IDX_MASK;
      d.pair_b        = a.user_b_index & wjd_pkg::IDX_MASK;
      d.union_empty   = (acc_union == 0);
      d.value_clipped = acc_clip;
      // empty union leaves the distance at zero
      if (acc_union != 0) begin
        quot = acc_sum / acc_union;
        if (quot > DIST_LOW_QUOT) begin
          d.distance      = D_MIN;
          d.value_clipped = 1'b1;
        end else begin
          d.distance = DIST_W'(UNIT_Q16 - quot);
        end
      end
      acc_sum   = '0;
      acc_union = '0;
      acc_clip  = 1'b0;
    end
  endfunction

  // Offer one article request, hold it until accepted, then log the
  // expectation and optionally idle the input.
  task automatic offer(input wjd_pkg::in_item_t item, input bit typed,
                       input wjd_pkg::out_item_t want);
    bit                 emits;
    wjd_pkg::out_item_t guess;
    int unsigned        gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    fold_article(item, emits, guess);
    if (emits) expected_distances.push_back(typed ? want : guess);
    gap = sender_idles ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid so nothing stale is re-accepted, then wait for every
  // outstanding result request.
  task automatic drain_results();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (expected_distances.size() != 0) @(posedge clk);
  endtask

  task automatic flag_field(input string field, input logic [31:0] want, got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  // Random user pairs, mostly short, some long; every pair ends on a last
  // article so it produces exactly one result.
  task automatic play_pairs(input int unsigned n_articles);
    int unsigned            sent;
    int unsigned            len;
    int unsigned            roll;
    logic [IDX_W-1:0]       ua, ub;
    wjd_pkg::in_item_t      a;
    sent = 0;
    while (sent < n_articles) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      ua  = IDX_W'($urandom);
      ub  = IDX_W'($urandom);
      for (int unsigned k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        a.user_a_index = ua;
        a.user_b_index = ub;
        // half both present, a third one-sided, the rest outside the union
        a.a_present    = (roll < 68);
        a.b_present    = (roll < 50) || (roll >= 68 && roll < 86);
        a.coef_a       = pick_coef();
        a.coef_b       = ($urandom_range(0, 7) == 0) ? a.coef_a : pick_coef();
        a.popularity   = pick_coef();
        a.last_article = (k == len - 1);
        offer(a, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // Result sink: checks every accepted result request against the oldest
  // expectation and drives out_ready, with random stalls or a long hold-off.
  initial begin : result_sink
    wjd_pkg::out_item_t want;
    int unsigned        stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_distances.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = expected_distances.pop_front();
          if (out_data.pair_a !== want.pair_a)
            flag_field("pair_a", 32'(want.pair_a), 32'(out_data.pair_a));
          if (out_data.pair_b !== want.pair_b)
            flag_field("pair_b", 32'(want.pair_b), 32'(out_data.pair_b));
          if (out_data.distance !== want.distance)
            flag_field("distance", want.distance, out_data.distance);
          if (out_data.union_empty !== want.union_empty)
            flag_field("union_empty", 32'(want.union_empty), 32'(out_data.union_empty));
          if (out_data.value_clipped !== want.value_clipped)
            flag_field("value_clipped", 32'(want.value_clipped), 32'(out_data.value_clipped));
        end
      end
      if (stall_left == 0) begin
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          stall_left   = HOLD_OFF_CYCLES;
        end else if (sink_idles) begin
          stall_left = idle_len();
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    // Directed corners. Hand-derived results where they are obvious,
    // the rest go through the model.
    // empty union straight after reset, index extremes
    plan.push_back(directed_row_t'{article(16'hFFFF, 16'h0000, 0, 0, C_MAX, C_MAX, C_MAX, 1),
                                   1'b1, pair_result(16'hFFFF, 16'h0000, 32'h0, 1, 0)});
    // equal coefficients, ratio exactly one: 1 - 1 = 0
    plan.push_back(directed_row_t'{article(16'h0000, 16'hFFFF, 1, 1, C_ONE, C_ONE, C_ONE, 1),
                                   1'b1, pair_result(16'h0000, 16'hFFFF, 32'h0, 0, 0)});
    // one-sided articles count toward the union only, zero coefs do not clip
    plan.push_back(directed_row_t'{article(16'h1234, 16'h5678, 1, 0, 0, 0, C_MAX, 1),
                                   1'b1, pair_result(16'h1234, 16'h5678, 32'h0001_0000, 0, 0)});
    plan.push_back(directed_row_t'{article(16'h00FF, 16'hFF00, 0, 1, C_MAX, 0, C_MAX, 1),
                                   1'b1, pair_result(16'h00FF, 16'hFF00, 32'h0001_0000, 0, 0)});
    // zero coefficient with zero popularity: flagged, sum stays zero
    plan.push_back(directed_row_t'{article(16'h0001, 16'h0002, 1, 1, 0, C_MAX, 0, 1),
                                   1'b1, pair_result(16'h0001, 16'h0002, 32'h0001_0000, 0, 1)});
    // both coefficients zero, full popularity: distance floors at -2^31
    plan.push_back(directed_row_t'{article(16'h0003, 16'h0004, 1, 1, 0, 0, C_MAX, 1),
                                   1'b1, pair_result(16'h0003, 16'h0004, D_MIN, 0, 1)});
    // ratio overflow: full scale ratio times 2^-16 gives 0xFFFF, distance 1 lsb
    plan.push_back(directed_row_t'{article(16'h0005, 16'h0006, 1, 1, C_MAX, 24'h1, 24'h1, 1),
                                   1'b1, pair_result(16'h0005, 16'h0006, 32'h1, 0, 1)});
    // largest ratio that still fits: same distance, no flag
    plan.push_back(directed_row_t'{article(16'h0007, 16'h0008, 1, 1, 24'h00FFFF, 24'h1,
                                           24'h1, 1),
                                   1'b1, pair_result(16'h0007, 16'h0008, 32'h1, 0, 0)});
    // ratio 2.0 times popularity 3.0: 1 - 6 = -5.0
    plan.push_back(directed_row_t'{article(16'h0009, 16'h000A, 1, 1, 24'h02_0000, C_ONE,
                                           24'h03_0000, 1),
                                   1'b1, pair_result(16'h0009, 16'h000A, 32'hFFFB_0000, 0, 0)});
    // mixed pair of four articles, one of them outside the union
    plan.push_back(directed_row_t'{article(16'hAAAA, 16'h5555, 1, 1, 24'h01_8000, C_ONE,
                                           24'h00_8000, 0), 1'b0, '0});
    plan.push_back(directed_row_t'{article(16'hAAAA, 16'h5555, 1, 0, C_MAX, C_ONE, C_MAX, 0),
                                   1'b0, '0});
    plan.push_back(directed_row_t'{article(16'hAAAA, 16'h5555, 0, 0, C_ONE, C_ONE, C_ONE, 0),
                                   1'b0, '0});
    plan.push_back(directed_row_t'{article(16'hAAAA, 16'h5555, 0, 1, C_ONE, 24'h3, C_ONE, 1),
                                   1'b0, '0});
    // empty union across two articles
    plan.push_back(directed_row_t'{article(16'h8000, 16'h0001, 0, 0, 0, C_MAX, C_ONE, 0),
                                   1'b0, '0});
    plan.push_back(directed_row_t'{article(16'h8000, 16'h0001, 0, 0, C_MAX, 0, 0, 1),
                                   1'b1, pair_result(16'h8000, 16'h0001, 32'h0, 1, 0)});
    // full scale equal coefficients and popularity
    plan.push_back(directed_row_t'{article(16'h7FFF, 16'h8000, 1, 1, C_MAX, C_MAX, C_MAX, 1),
                                   1'b0, '0});
    // smallest nonzero coefficients, ratio one
    plan.push_back(directed_row_t'{article(16'h0F00, 16'h00F0, 1, 1, 24'h1, 24'h1, C_ONE, 1),
                                   1'b1, pair_result(16'h0F00, 16'h00F0, 32'h0, 0, 0)});
    // quotient exactly 2^31 + 1.0: distance lands on -2^31 without clipping
    plan.push_back(directed_row_t'{article(16'h0011, 16'h0022, 1, 1, 24'h80_0100, 24'h00_0100,
                                           C_ONE, 1),
                                   1'b1, pair_result(16'h0011, 16'h0022, D_MIN, 0, 0)});
    // one step past it: saturated and flagged
    plan.push_back(directed_row_t'{article(16'h0033, 16'h0044, 1, 1, 24'h80_0101, 24'h00_0100,
                                           C_ONE, 1),
                                   1'b1, pair_result(16'h0033, 16'h0044, D_MIN, 0, 1)});

    // synchronous reset, applied once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i].req, plan[i].typed, plan[i].want);

    // random pairs, both sides idling
    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    play_pairs(300);

    // sender pauses for a full drain, then the sink holds off for a long
    // stretch while requests keep coming, so the block backs up its input
    drain_results();
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    hold_off_req = 1'b1;
    play_pairs(16);

    // no idling on either side
    play_pairs(300);

    // idling again
    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    play_pairs(250);

    drain_results();
    // room for any stray result after the final division
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wjd_pkg.sv
rtl/weighted_jaccard_distance.sv
verif/weighted_jaccard_distance_tb.sv
